// ===== rtl/isdn_layer3_call_control_top_macros.svh =====
// assertion macros for the call control block
`ifndef ISDN_LAYER3_CALL_CONTROL_TOP_MACROS_SVH
`define ISDN_LAYER3_CALL_CONTROL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define L3_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define L3_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define L3_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define L3_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== rtl/isdn_l3cc_pkg.sv =====
package isdn_l3cc_pkg;

    localparam logic [3:0] OP_TICK = 4'd0;
    localparam logic [3:0] OP_SETUP = 4'd1;
    localparam logic [3:0] OP_DISC = 4'd2;
    localparam logic [3:0] OP_REL = 4'd3;
    localparam logic [3:0] OP_LOST = 4'd4;
    localparam logic [3:0] OP_IGNORE = 4'd5;
    localparam logic [3:0] OP_REJECT = 4'd6;
    localparam logic [3:0] OP_ALERT = 4'd7;
    localparam logic [3:0] OP_ANSWER = 4'd8;
    localparam logic [3:0] OP_PEER = 4'd9;

    localparam logic [7:0] MT_ALERT = 8'h01;
    localparam logic [7:0] MT_PROC = 8'h02;
    localparam logic [7:0] MT_SETUP = 8'h05;
    localparam logic [7:0] MT_CONN = 8'h07;
    localparam logic [7:0] MT_SACK = 8'h0D;
    localparam logic [7:0] MT_CACK = 8'h0F;
    localparam logic [7:0] MT_DISC = 8'h45;
    localparam logic [7:0] MT_REL = 8'h4D;
    localparam logic [7:0] MT_RELC = 8'h5A;
    localparam logic [7:0] MT_STENQ = 8'h75;
    localparam logic [7:0] MT_STATUS = 8'h7D;
    localparam logic [7:0] PD_Q931 = 8'h08;

    localparam logic [2:0] TK_NONE = 3'd0;
    localparam logic [2:0] TK_T303 = 3'd1;
    localparam logic [2:0] TK_T304 = 3'd2;
    localparam logic [2:0] TK_T305 = 3'd3;
    localparam logic [2:0] TK_T308A = 3'd4;
    localparam logic [2:0] TK_T308B = 3'd5;
    localparam logic [2:0] TK_T310 = 3'd6;
    localparam logic [2:0] TK_T313 = 3'd7;

    localparam logic [3:0] IND_SETUP = 4'd0;
    localparam logic [3:0] IND_MORE = 4'd1;
    localparam logic [3:0] IND_PROC = 4'd2;
    localparam logic [3:0] IND_ALERT = 4'd3;
    localparam logic [3:0] IND_CONF = 4'd4;
    localparam logic [3:0] IND_COMPL = 4'd5;
    localparam logic [3:0] IND_DISC = 4'd6;
    localparam logic [3:0] IND_REL = 4'd7;
    localparam logic [3:0] IND_RELCONF = 4'd8;
    localparam logic [3:0] IND_NORESP = 4'd9;
    localparam logic [3:0] IND_SETUPERR = 4'd10;
    localparam logic [3:0] IND_CONNERR = 4'd11;
    localparam logic [3:0] IND_RELERR = 4'd12;

    localparam logic [2:0] REG_SETUP = 3'd0;
    localparam logic [2:0] REG_OVERLAP = 3'd1;
    localparam logic [2:0] REG_DISC = 3'd2;
    localparam logic [2:0] REG_REL = 3'd3;
    localparam logic [2:0] REG_PROC = 3'd4;
    localparam logic [2:0] REG_CACK = 3'd5;
    localparam logic [2:0] REG_RETRY = 3'd6;

    localparam logic [31:0] REL_STATES = 32'h000A_9D9F;
    localparam logic [31:0] DISC_REQ_STATES = 32'h0000_05DE;
    localparam logic [31:0] DISC_PEER_STATES = 32'h0000_059E;

    // one result word, before the state fields are added
    typedef struct packed {
        logic       kind;
        logic [7:0] msg;
        logic [7:0] cref;
        logic [7:0] cause;
        logic       cause_valid;
        logic [3:0] ind;
    } t_res;

    function automatic logic [2:0] svc_map(input logic [4:0] cap);
        logic [2:0] s;
        case (cap)
            5'h00, 5'h10: s = 3'd1;
            5'h08:        s = 3'd7;
            5'h09:        s = 3'd2;
            5'h11:        s = 3'd3;
            5'h18:        s = 3'd4;
            default:      s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/isdn_layer3_call_control_top.sv =====
// channel     | dir | handshake        | payload
// s_axis      | in  | tvalid / tready  | tdata event word
// m_axis      | out | tvalid / tready  | tdata result word, tuser kind, tlast
// cfg         | in  | valid / ready    | index 3b, data 16b
// one event word is taken per cycle into an input register, unless a held
// word waits; the whole step is then worked out and loads up to two results
// into a small queue; an event that yields two results is sent as two output
// words, so the sustained rate is set by the output port
// reset is synchronous, active low, clearing state and control registers to defaults
// a stalled output holds the queue; input stalls while a held word waits on it
`include "isdn_layer3_call_control_top_macros.svh"
module isdn_layer3_call_control_top #(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[3:0] disc[11:4] mt[19:12] cref[26:20] cp[27] lp[28] loc[36:29]
    // cause[44:37] chp[45] choct[53:46] bp[54] boct[62:55], pad to 64
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // msg[7:0] cref[15:8] cause[23:16] cv[24] loc[32:25] state[37:33]
    // ind[41:38] bch[43:42] svc[46:44], pad to 48
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,  // kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int TB = TIMER_BITS;

    // configuration
    logic [15:0] r_to [6];
    logic [2:0]  r_retries;

    // call state
    logic [4:0]    r_cs;
    logic [2:0]    r_tk;
    logic [TB-1:0] r_tl;
    logic [2:0]    r_rl;
    logic [7:0]    r_cref, r_cause, r_loc;
    logic          r_ck;
    logic [1:0]    r_bch;
    logic [2:0]    r_svc;

    // input register
    logic        r_iv;
    logic [62:0] r_in;

    // result queue, depth two, each entry a full output word
    logic [49:0] r_q [2];
    logic [1:0]  r_qn;
    logic        r_qh;

    assign o_cfg_ready = 1'b1;
    // accept only if the queue has room for the worst case of the held word
    wire step_go = r_iv && (r_qn == 2'd0 || (r_qn == 2'd1 && m_axis_tready));
    assign s_axis_tready = !r_iv || step_go;

    wire [3:0] op   = r_in[3:0];
    wire [7:0] pd   = r_in[11:4];
    wire [7:0] mt   = r_in[19:12];
    wire [6:0] icr  = r_in[26:20];
    wire       cp   = r_in[27];
    wire       lp   = r_in[28];
    wire [7:0] iloc = r_in[36:29];
    wire [7:0] icv  = r_in[44:37];
    wire       chp  = r_in[45];
    wire [7:0] choct = r_in[53:46];
    wire       bp   = r_in[54];
    wire [7:0] boct = r_in[62:55];

    function automatic logic [TB-1:0] sat(input logic [15:0] v);
        logic [TB-1:0] r;
        if (TB >= 16) r = TB'(v);
        else if ((v >> TB) != 16'd0) r = '1;
        else r = TB'(v);
        return r;
    endfunction

    logic [4:0] n_cs; logic [2:0] n_tk; logic [TB-1:0] n_tl; logic [2:0] n_rl;
    logic [7:0] n_cref, n_cause, n_loc; logic n_ck; logic [1:0] n_bch; logic [2:0] n_svc;
    isdn_l3cc_pkg::t_res res [2];
    logic [1:0] nres;

    always_comb begin
        logic [7:0] c;
        n_cs = r_cs; n_tk = r_tk; n_tl = r_tl; n_rl = r_rl; n_cref = r_cref;
        n_cause = r_cause; n_loc = r_loc; n_ck = r_ck; n_bch = r_bch; n_svc = r_svc;
        res[0] = '0; res[1] = '0; nres = 2'd0; c = '0;
        case (op)
            isdn_l3cc_pkg::OP_TICK: begin
                if (r_tk != isdn_l3cc_pkg::TK_NONE) begin
                    if (r_tl <= TB'(1)) begin
                        n_tk = isdn_l3cc_pkg::TK_NONE; n_tl = '0;
                        if (r_tk == isdn_l3cc_pkg::TK_T303 && r_cs == 5'd1) begin
                            if (r_rl != 3'd0) begin
                                n_rl = r_rl - 3'd1;
                                res[0] = '{1'b0, isdn_l3cc_pkg::MT_SETUP, r_cref, 8'd0,
                                           1'b0, 4'd0};
                                nres = 2'd1;
                                n_tk = isdn_l3cc_pkg::TK_T303;
                                n_tl = sat(r_to[isdn_l3cc_pkg::REG_SETUP]);
                            end else begin
                                n_cs = 5'd0;
                                res[0] = '{1'b1, 8'd0, 8'd0, r_ck ? r_cause : 8'd0, r_ck,
                                           isdn_l3cc_pkg::IND_NORESP};
                                nres = 2'd1; n_rl = r_retries;
                            end
                        end else if ((r_tk == isdn_l3cc_pkg::TK_T304 && r_cs == 5'd2) ||
                                     (r_tk == isdn_l3cc_pkg::TK_T310 && r_cs == 5'd3) ||
                                     (r_tk == isdn_l3cc_pkg::TK_T313 && r_cs == 5'd8)) begin
                            // timer-driven disconnect with cause 0xe6
                            n_cause = 8'hE6; n_ck = 1'b1;
                            res[0] = '{1'b0, isdn_l3cc_pkg::MT_DISC, r_cref, 8'hE6, 1'b1, 4'd0};
                            res[1] = '{1'b1, 8'd0, 8'd0, 8'hE6, 1'b1,
                                       (r_tk == isdn_l3cc_pkg::TK_T313) ?
                                       isdn_l3cc_pkg::IND_CONNERR : isdn_l3cc_pkg::IND_SETUPERR};
                            nres = 2'd2; n_cs = 5'd11;
                            n_tk = isdn_l3cc_pkg::TK_T305;
                            n_tl = sat(r_to[isdn_l3cc_pkg::REG_DISC]);
                        end else if (r_tk == isdn_l3cc_pkg::TK_T305 && r_cs == 5'd11) begin
                            c = (r_ck && r_cause != 8'd0) ? r_cause : 8'h90;
                            res[0] = '{1'b0, isdn_l3cc_pkg::MT_REL, r_cref, c, 1'b1, 4'd0};
                            nres = 2'd1; n_cs = 5'd19;
                            n_tk = isdn_l3cc_pkg::TK_T308A;
                            n_tl = sat(r_to[isdn_l3cc_pkg::REG_REL]);
                        end else if (r_tk == isdn_l3cc_pkg::TK_T308A && r_cs == 5'd19) begin
                            res[0] = '{1'b0, isdn_l3cc_pkg::MT_REL, r_cref, 8'd0, 1'b0, 4'd0};
                            nres = 2'd1;
                            n_tk = isdn_l3cc_pkg::TK_T308B;
                            n_tl = sat(r_to[isdn_l3cc_pkg::REG_REL]);
                        end else if (r_tk == isdn_l3cc_pkg::TK_T308B && r_cs == 5'd19) begin
                            n_cs = 5'd0;
                            res[0] = '{1'b1, 8'd0, 8'd0, r_ck ? r_cause : 8'd0, r_ck,
                                       isdn_l3cc_pkg::IND_RELERR};
                            nres = 2'd1;
                        end
                    end else begin
                        n_tl = r_tl - TB'(1);
                    end
                end
            end
            isdn_l3cc_pkg::OP_SETUP: begin
                if (r_cs == 5'd0) begin
                    n_cref = {1'b0, icr};
                    res[0] = '{1'b0, isdn_l3cc_pkg::MT_SETUP, {1'b0, icr}, 8'd0, 1'b0, 4'd0};
                    nres = 2'd1; n_cs = 5'd1;
                    n_tk = isdn_l3cc_pkg::TK_T303;
                    n_tl = sat(r_to[isdn_l3cc_pkg::REG_SETUP]);
                end
            end
            isdn_l3cc_pkg::OP_DISC: begin
                if (isdn_l3cc_pkg::DISC_REQ_STATES[r_cs]) begin
                    n_cause = icv; n_ck = 1'b1;
                    c = ((icv != 8'd0) ? icv : 8'h10) | 8'h80;
                    res[0] = '{1'b0, isdn_l3cc_pkg::MT_DISC, r_cref, c, 1'b1, 4'd0};
                    nres = 2'd1; n_cs = 5'd11;
                    n_tk = isdn_l3cc_pkg::TK_T305;
                    n_tl = sat(r_to[isdn_l3cc_pkg::REG_DISC]);
                end
            end
            isdn_l3cc_pkg::OP_REL: begin
                if (r_cs == 5'd12) begin
                    n_cs = 5'd19;
                    res[0] = '{1'b0, isdn_l3cc_pkg::MT_REL, r_cref, 8'd0, 1'b0, 4'd0};
                    nres = 2'd1;
                    n_tk = isdn_l3cc_pkg::TK_T308A;
                    n_tl = sat(r_to[isdn_l3cc_pkg::REG_REL]);
                end
            end
            isdn_l3cc_pkg::OP_LOST: begin
                n_tk = isdn_l3cc_pkg::TK_NONE; n_tl = '0; n_cs = 5'd0;
            end
            isdn_l3cc_pkg::OP_IGNORE: begin
                if (r_cs == 5'd6) begin
                    n_tk = isdn_l3cc_pkg::TK_NONE; n_tl = '0; n_cs = 5'd0;
                end
            end
            isdn_l3cc_pkg::OP_REJECT: begin
                if (r_cs == 5'd6) begin
                    n_cause = icv; n_ck = 1'b1;
                    c = (icv != 8'd0) ? icv : 8'h95;
                    res[0] = '{1'b0, isdn_l3cc_pkg::MT_RELC, r_cref, c, 1'b1, 4'd0};
                    res[1] = '{1'b1, 8'd0, 8'd0, icv, 1'b1, isdn_l3cc_pkg::IND_REL};
                    nres = 2'd2; n_cs = 5'd0;
                end
            end
            isdn_l3cc_pkg::OP_ALERT: begin
                if (r_cs == 5'd6) begin
                    n_cs = 5'd7;
                    res[0] = '{1'b0, isdn_l3cc_pkg::MT_ALERT, r_cref, 8'd0, 1'b0, 4'd0};
                    nres = 2'd1;
                end
            end
            isdn_l3cc_pkg::OP_ANSWER: begin
                if (r_cs == 5'd6 || r_cs == 5'd7) begin
                    n_cs = 5'd8;
                    res[0] = '{1'b0, isdn_l3cc_pkg::MT_CONN, r_cref, 8'd0, 1'b0, 4'd0};
                    nres = 2'd1;
                    n_tk = isdn_l3cc_pkg::TK_T313;
                    n_tl = sat(r_to[isdn_l3cc_pkg::REG_CACK]);
                end
            end
            isdn_l3cc_pkg::OP_PEER: begin
                if (pd == isdn_l3cc_pkg::PD_Q931) begin
                    if (mt == isdn_l3cc_pkg::MT_STENQ) begin
                        res[0] = '{1'b0, isdn_l3cc_pkg::MT_STATUS, r_cref, 8'h9E, 1'b1, 4'd0};
                        nres = 2'd1;
                    end else if (mt == isdn_l3cc_pkg::MT_SETUP &&
                                 (r_cs == 5'd0 || r_cs == 5'd6)) begin
                        n_cref = 8'h80 + {1'b0, icr};
                        if (bp) n_svc = isdn_l3cc_pkg::svc_map(boct[4:0]);
                        if (chp) n_bch = choct[1:0];
                        if (chp && choct[1:0] != 2'd0) begin
                            n_cs = 5'd6;
                            res[0] = '{1'b1, 8'd0, 8'd0, r_ck ? r_cause : 8'd0, r_ck,
                                       isdn_l3cc_pkg::IND_SETUP};
                            nres = 2'd1;
                        end
                    end else if (mt == isdn_l3cc_pkg::MT_PROC &&
                                 (r_cs == 5'd1 || r_cs == 5'd2)) begin
                        if (chp) n_bch = choct[1:0];
                        n_cs = 5'd3;
                        n_tk = isdn_l3cc_pkg::TK_T310;
                        n_tl = sat(r_to[isdn_l3cc_pkg::REG_PROC]);
                        res[0] = '{1'b1, 8'd0, 8'd0, r_ck ? r_cause : 8'd0, r_ck,
                                   isdn_l3cc_pkg::IND_PROC};
                        nres = 2'd1;
                    end else if (mt == isdn_l3cc_pkg::MT_SACK && r_cs == 5'd1) begin
                        if (chp) n_bch = choct[1:0];
                        n_cs = 5'd2;
                        n_tk = isdn_l3cc_pkg::TK_T304;
                        n_tl = sat(r_to[isdn_l3cc_pkg::REG_OVERLAP]);
                        res[0] = '{1'b1, 8'd0, 8'd0, r_ck ? r_cause : 8'd0, r_ck,
                                   isdn_l3cc_pkg::IND_MORE};
                        nres = 2'd1;
                    end else if (mt == isdn_l3cc_pkg::MT_ALERT &&
                                 (r_cs == 5'd1 || r_cs == 5'd2 || r_cs == 5'd3)) begin
                        n_tk = isdn_l3cc_pkg::TK_NONE; n_tl = '0; n_cs = 5'd4;
                        res[0] = '{1'b1, 8'd0, 8'd0, r_ck ? r_cause : 8'd0, r_ck,
                                   isdn_l3cc_pkg::IND_ALERT};
                        nres = 2'd1;
                    end else if ((mt == isdn_l3cc_pkg::MT_RELC || mt == isdn_l3cc_pkg::MT_REL)
                                 && isdn_l3cc_pkg::REL_STATES[r_cs]) begin
                        if (mt == isdn_l3cc_pkg::MT_RELC) n_loc = 8'd0;
                        if (cp) begin
                            if (lp) n_loc = iloc;
                            n_cause = {1'b0, icv[6:0]}; n_ck = 1'b1;
                        end else begin
                            n_ck = 1'b0;
                        end
                        n_tk = isdn_l3cc_pkg::TK_NONE; n_tl = '0; n_cs = 5'd0;
                        if (mt == isdn_l3cc_pkg::MT_REL) begin
                            res[0] = '{1'b0, isdn_l3cc_pkg::MT_RELC, r_cref, 8'd0, 1'b0, 4'd0};
                            res[1] = '{1'b1, 8'd0, 8'd0, cp ? {1'b0, icv[6:0]} : 8'd0, cp,
                                       isdn_l3cc_pkg::IND_REL};
                            nres = 2'd2;
                        end else begin
                            res[0] = '{1'b1, 8'd0, 8'd0, cp ? {1'b0, icv[6:0]} : 8'd0, cp,
                                       isdn_l3cc_pkg::IND_RELCONF};
                            nres = 2'd1;
                        end
                    end else if (mt == isdn_l3cc_pkg::MT_DISC &&
                                 isdn_l3cc_pkg::DISC_PEER_STATES[r_cs]) begin
                        n_tk = isdn_l3cc_pkg::TK_NONE; n_tl = '0;
                        n_loc = (cp && lp) ? iloc : 8'd0;
                        if (cp) begin
                            n_cause = {1'b0, icv[6:0]}; n_ck = 1'b1;
                        end else begin
                            n_ck = 1'b0;
                        end
                        n_cs = 5'd12;
                        res[0] = '{1'b1, 8'd0, 8'd0, cp ? {1'b0, icv[6:0]} : 8'd0, cp,
                                   isdn_l3cc_pkg::IND_DISC};
                        nres = 2'd1;
                    end else if (mt == isdn_l3cc_pkg::MT_CONN && (r_cs == 5'd1 ||
                                 r_cs == 5'd2 || r_cs == 5'd3 || r_cs == 5'd4)) begin
                        n_tk = isdn_l3cc_pkg::TK_NONE; n_tl = '0; n_cs = 5'd10;
                        res[0] = '{1'b1, 8'd0, 8'd0, r_ck ? r_cause : 8'd0, r_ck,
                                   isdn_l3cc_pkg::IND_CONF};
                        nres = 2'd1;
                    end else if (mt == isdn_l3cc_pkg::MT_CACK && r_cs == 5'd8) begin
                        n_tk = isdn_l3cc_pkg::TK_NONE; n_tl = '0; n_cs = 5'd10;
                        res[0] = '{1'b1, 8'd0, 8'd0, r_ck ? r_cause : 8'd0, r_ck,
                                   isdn_l3cc_pkg::IND_COMPL};
                        nres = 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // full output word: {last, kind, tdata}
    function automatic logic [49:0] pack(input isdn_l3cc_pkg::t_res r, input logic l,
                                         input logic [7:0] lo, input logic [4:0] s,
                                         input logic [1:0] b, input logic [2:0] v);
        return {l, r.kind, 1'b0, v, b, r.ind, s, lo, r.cause_valid, r.cause, r.cref, r.msg};
    endfunction

    wire pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_to[0] <= 16'd4000; r_to[1] <= 16'd30000; r_to[2] <= 16'd30000;
            r_to[3] <= 16'd4000; r_to[4] <= 16'd30000; r_to[5] <= 16'd4000;
            r_retries <= 3'd1;
            r_cs <= '0; r_tk <= isdn_l3cc_pkg::TK_NONE; r_tl <= '0; r_rl <= 3'd1;
            r_cref <= '0; r_cause <= '0; r_ck <= 1'b0; r_loc <= '0;
            r_bch <= '0; r_svc <= '0;
            r_iv <= 1'b0; r_qn <= '0; r_qh <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_iv <= 1'b1; r_in <= s_axis_tdata[62:0];
            end else if (step_go) begin
                r_iv <= 1'b0;
            end
            if (step_go) begin
                r_cs <= n_cs; r_tk <= n_tk; r_tl <= n_tl; r_rl <= n_rl; r_cref <= n_cref;
                r_cause <= n_cause; r_ck <= n_ck; r_loc <= n_loc;
                r_bch <= n_bch; r_svc <= n_svc;
            end
            // queue: at step_go either empty, or one entry being popped now
            if (step_go) begin
                r_q[0] <= pack(res[0], nres == 2'd1, n_loc, n_cs, n_bch, n_svc);
                r_q[1] <= pack(res[1], 1'b1, n_loc, n_cs, n_bch, n_svc);
                r_qn <= nres; r_qh <= 1'b0;
            end else if (pop) begin
                r_qn <= r_qn - 2'd1; r_qh <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    isdn_l3cc_pkg::REG_SETUP, isdn_l3cc_pkg::REG_OVERLAP,
                    isdn_l3cc_pkg::REG_DISC, isdn_l3cc_pkg::REG_REL,
                    isdn_l3cc_pkg::REG_PROC, isdn_l3cc_pkg::REG_CACK:
                        r_to[i_cfg_index] <= i_cfg_data;
                    isdn_l3cc_pkg::REG_RETRY: begin
                        r_retries <= i_cfg_data[2:0]; r_rl <= i_cfg_data[2:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = (r_qn != 2'd0);
    assign m_axis_tdata  = r_q[r_qh][47:0];
    assign m_axis_tuser  = r_q[r_qh][48];
    assign m_axis_tlast  = r_q[r_qh][49];

    `L3_ASSERT_IMP(a_qn_range, i_clk, i_rst_n, 1'b1, r_qn != 2'd3, "queue count out of range")
    `L3_ASSERT_IMP(a_no_timer_idle, i_clk, i_rst_n, r_tk == isdn_l3cc_pkg::TK_NONE,
        r_tl == '0, "timer count without a timer")
    `L3_ASSERT_IMP(a_step_room, i_clk, i_rst_n, step_go, r_qn == 2'd0 || pop,
        "step with queue occupied")
    `L3_ASSERT_NXT(a_second_last, i_clk, i_rst_n, pop && r_qn == 2'd2 && !step_go,
        m_axis_tlast, "second result not marked last")
endmodule
